>>> rtl/wbrp_pkg.sv
package wbrp_pkg;

   // header layout
   localparam logic [3:0] SEQ_BYTES    = 4'd8;
   localparam logic [3:0] HEADER_BYTES = 4'd12;

   // longest varint32, counted from zero
   localparam logic [2:0] VARINT_LAST = 3'd4;

   // configuration register indexes
   localparam logic CSR_PUT_TAG    = 1'b0;
   localparam logic CSR_DELETE_TAG = 1'b1;

   // reset values of the tag registers
   localparam logic [7:0] PUT_TAG_RESET    = 8'd1;
   localparam logic [7:0] DELETE_TAG_RESET = 8'd0;

   // byte roles
   localparam logic [2:0] ROLE_HEADER  = 3'd0;
   localparam logic [2:0] ROLE_TAG     = 3'd1;
   localparam logic [2:0] ROLE_KEYLEN  = 3'd2;
   localparam logic [2:0] ROLE_KEY     = 3'd3;
   localparam logic [2:0] ROLE_VALLEN  = 3'd4;
   localparam logic [2:0] ROLE_VAL     = 3'd5;
   localparam logic [2:0] ROLE_DISCARD = 3'd6;

   // batch status codes
   localparam logic [2:0] STATUS_OK          = 3'd0;
   localparam logic [2:0] STATUS_TOO_SMALL   = 3'd1;
   localparam logic [2:0] STATUS_BAD_PUT     = 3'd2;
   localparam logic [2:0] STATUS_BAD_DELETE  = 3'd3;
   localparam logic [2:0] STATUS_UNKNOWN_TAG = 3'd4;
   localparam logic [2:0] STATUS_WRONG_COUNT = 3'd5;

   // parser phase
   typedef enum logic [2:0] {
      PH_HEADER  = 3'd0,
      PH_TAG     = 3'd1,
      PH_KEYLEN  = 3'd2,
      PH_KEY     = 3'd3,
      PH_VALLEN  = 3'd4,
      PH_VAL     = 3'd5,
      PH_DISCARD = 3'd6
   } phase_type;

   // parser state carried from byte to byte
   typedef struct packed {
      phase_type   phase;
      logic [3:0]  header_index;
      logic [63:0] next_sequence;
      logic [31:0] expected_count;
      logic [31:0] records_found;
      logic [31:0] length_accum;
      logic [2:0]  varint_bytes;
      logic [31:0] bytes_left;
      logic        is_delete;
      logic [2:0]  error_code;
   } parse_state_type;

   localparam parse_state_type STATE_CLEAR = '{
      phase:          PH_HEADER,
      header_index:   4'd0,
      next_sequence:  64'd0,
      expected_count: 32'd0,
      records_found:  32'd0,
      length_accum:   32'd0,
      varint_bytes:   3'd0,
      bytes_left:     32'd0,
      is_delete:      1'b0,
      error_code:     STATUS_OK
   };

   // one labelled output item
   typedef struct packed {
      logic [2:0]  role;
      logic [7:0]  byte_out;
      logic        op;
      logic [63:0] record_seq;
      logic        key_end;
      logic        record_end;
      logic        batch_done;
      logic [2:0]  status;
   } result_type;

endpackage

>>> rtl/wbrp_if.sv
interface wbrp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last;

   modport source (output valid, output data_byte, output last, input ready);
   modport sink (input valid, input data_byte, input last, output ready);
endinterface

interface wbrp_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  role;
   logic [7:0]  byte_out;
   logic        op;
   logic [63:0] record_seq;
   logic        key_end;
   logic        record_end;
   logic        batch_done;
   logic [2:0]  status;

   modport source (output valid, output role, output byte_out, output op,
                   output record_seq, output key_end, output record_end,
                   output batch_done, output status, input ready);
   modport sink (input valid, input role, input byte_out, input op,
                 input record_seq, input key_end, input record_end,
                 input batch_done, input status, output ready);
endinterface

interface wbrp_csr_if;
   logic       valid;
   logic       ready;
   logic       index;
   logic [7:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/wbrp_step.sv
module wbrp_step
   import wbrp_pkg::*;
(
   input  parse_state_type cur_state,
   input  logic [7:0]      data_byte,
   input  logic            last,
   input  logic [7:0]      put_tag,
   input  logic [7:0]      delete_tag,
   output parse_state_type next_state,
   output result_type      result
);

   logic [63:0] seq_slot;
   logic [31:0] cnt_slot;
   logic [31:0] len_slot;
   logic [31:0] accum;
   logic [31:0] left_dec;
   logic        rec_role;
   logic        key_len;

   // header byte placement, little-endian
   assign seq_slot = {56'd0, data_byte} << {cur_state.header_index[2:0], 3'b000};
   assign cnt_slot = {24'd0, data_byte} << {cur_state.header_index[1:0], 3'b000};

   // seven payload bits of a varint byte at their place
   always_comb begin
      case (cur_state.varint_bytes)
         3'd0:    len_slot = {25'd0, data_byte[6:0]};
         3'd1:    len_slot = {18'd0, data_byte[6:0], 7'd0};
         3'd2:    len_slot = {11'd0, data_byte[6:0], 14'd0};
         3'd3:    len_slot = {4'd0, data_byte[6:0], 21'd0};
         3'd4:    len_slot = {data_byte[3:0], 28'd0};
         default: len_slot = 32'd0;
      endcase
   end

   assign accum    = cur_state.length_accum | len_slot;
   assign left_dec = cur_state.bytes_left - 32'd1;
   assign key_len  = (cur_state.phase == PH_KEYLEN);

   // per-byte parse
   always_comb begin
      next_state        = cur_state;
      rec_role          = 1'b0;
      result.role       = ROLE_DISCARD;
      result.byte_out   = data_byte;
      result.key_end    = 1'b0;
      result.record_end = 1'b0;
      result.batch_done = 1'b0;
      result.status     = STATUS_OK;

      unique case (cur_state.phase) inside
         PH_HEADER: begin
            result.role = ROLE_HEADER;
            if (cur_state.header_index < SEQ_BYTES) begin
               next_state.next_sequence = cur_state.next_sequence | seq_slot;
            end else if (cur_state.header_index < HEADER_BYTES) begin
               next_state.expected_count = cur_state.expected_count | cnt_slot;
            end
            next_state.header_index = cur_state.header_index + 4'd1;
            if (next_state.header_index >= HEADER_BYTES) begin
               next_state.phase = PH_TAG;
            end
         end
         PH_TAG: begin
            result.role              = ROLE_TAG;
            rec_role                 = 1'b1;
            next_state.records_found = cur_state.records_found + 32'd1;
            next_state.length_accum  = 32'd0;
            next_state.varint_bytes  = 3'd0;
            if (data_byte == put_tag) begin
               next_state.is_delete = 1'b0;
               next_state.phase     = PH_KEYLEN;
            end else if (data_byte == delete_tag) begin
               next_state.is_delete = 1'b1;
               next_state.phase     = PH_KEYLEN;
            end else begin
               next_state.is_delete  = 1'b0;
               next_state.error_code = STATUS_UNKNOWN_TAG;
               next_state.phase      = PH_DISCARD;
            end
         end
         PH_KEYLEN, PH_VALLEN: begin
            result.role             = key_len ? ROLE_KEYLEN : ROLE_VALLEN;
            rec_role                = 1'b1;
            next_state.length_accum = accum;
            if (data_byte[7]) begin
               // continuation bit; a fifth such byte is an overlong varint
               if (cur_state.varint_bytes >= VARINT_LAST) begin
                  next_state.error_code = cur_state.is_delete ? STATUS_BAD_DELETE
                                                              : STATUS_BAD_PUT;
                  next_state.phase      = PH_DISCARD;
               end else begin
                  next_state.varint_bytes = cur_state.varint_bytes + 3'd1;
               end
            end else begin
               next_state.varint_bytes = 3'd0;
               if (accum == 32'd0) begin
                  // empty key or value ends here
                  if (key_len && !cur_state.is_delete) begin
                     result.key_end          = 1'b1;
                     next_state.phase        = PH_VALLEN;
                     next_state.length_accum = 32'd0;
                  end else begin
                     result.key_end           = key_len;
                     result.record_end        = 1'b1;
                     next_state.next_sequence = cur_state.next_sequence + 64'd1;
                     next_state.phase         = PH_TAG;
                  end
               end else begin
                  next_state.bytes_left = accum;
                  next_state.phase      = key_len ? PH_KEY : PH_VAL;
               end
            end
         end
         PH_KEY: begin
            result.role           = ROLE_KEY;
            rec_role              = 1'b1;
            next_state.bytes_left = left_dec;
            if (left_dec == 32'd0) begin
               result.key_end = 1'b1;
               if (cur_state.is_delete) begin
                  result.record_end        = 1'b1;
                  next_state.next_sequence = cur_state.next_sequence + 64'd1;
                  next_state.phase         = PH_TAG;
               end else begin
                  next_state.phase        = PH_VALLEN;
                  next_state.length_accum = 32'd0;
                  next_state.varint_bytes = 3'd0;
               end
            end
         end
         PH_VAL: begin
            result.role           = ROLE_VAL;
            rec_role              = 1'b1;
            next_state.bytes_left = left_dec;
            if (left_dec == 32'd0) begin
               result.record_end        = 1'b1;
               next_state.next_sequence = cur_state.next_sequence + 64'd1;
               next_state.phase         = PH_TAG;
            end
         end
         default: begin
            result.role = ROLE_DISCARD;
         end
      endcase

      result.op         = rec_role ? next_state.is_delete : 1'b0;
      result.record_seq = rec_role ? cur_state.next_sequence : 64'd0;

      // final byte: report and start a new batch
      if (last) begin
         result.batch_done = 1'b1;
         if (next_state.error_code != STATUS_OK) begin
            result.status = next_state.error_code;
         end else if (next_state.phase == PH_HEADER) begin
            result.status = STATUS_TOO_SMALL;
         end else if (next_state.phase != PH_TAG) begin
            result.status = next_state.is_delete ? STATUS_BAD_DELETE : STATUS_BAD_PUT;
         end else if (next_state.records_found != next_state.expected_count) begin
            result.status = STATUS_WRONG_COUNT;
         end else begin
            result.status = STATUS_OK;
         end
         next_state = STATE_CLEAR;
      end
   end

endmodule

>>> rtl/write_batch_record_parser.sv
// an accepted byte's result is registered and is on the result port in the next cycle
// throughput: one byte per cycle unless stalled; a byte's parse is a single registered step
// a result held back by the receiver stalls the input until it is taken
// reset (synchronous, active high): parser back to the header phase, tag registers
// to put 1 and delete 0, result register empty
module write_batch_record_parser
   import wbrp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   wbrp_req_if.sink   req_chan,
   wbrp_rsp_if.source rsp_chan,
   wbrp_csr_if.sink   csr_chan
);

   parse_state_type state_ff;
   parse_state_type state_in;
   result_type      result_ff;
   result_type      result_in;
   logic            rsp_valid_ff;
   logic [7:0]      put_tag_ff;
   logic [7:0]      delete_tag_ff;
   logic            req_ready;
   logic            req_accept;

   // input taken whenever the result register is empty or being drained
   assign req_ready      = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = req_ready;
   assign req_accept     = req_chan.valid && req_ready;
   assign csr_chan.ready = 1'b1;

   // tag registers
   always_ff @(posedge clock) begin
      if (reset) begin
         put_tag_ff    <= PUT_TAG_RESET;
         delete_tag_ff <= DELETE_TAG_RESET;
      end else if (csr_chan.valid) begin
         if (csr_chan.index == CSR_PUT_TAG) begin
            put_tag_ff <= csr_chan.data;
         end
         if (csr_chan.index == CSR_DELETE_TAG) begin
            delete_tag_ff <= csr_chan.data;
         end
      end
   end

   wbrp_step u_step (
      .cur_state  (state_ff),
      .data_byte  (req_chan.data_byte),
      .last       (req_chan.last),
      .put_tag    (put_tag_ff),
      .delete_tag (delete_tag_ff),
      .next_state (state_in),
      .result     (result_in)
   );

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_CLEAR;
      end else if (req_accept) begin
         state_ff <= state_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         result_ff <= result_in;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.role       = result_ff.role;
   assign rsp_chan.byte_out   = result_ff.byte_out;
   assign rsp_chan.op         = result_ff.op;
   assign rsp_chan.record_seq = result_ff.record_seq;
   assign rsp_chan.key_end    = result_ff.key_end;
   assign rsp_chan.record_end = result_ff.record_end;
   assign rsp_chan.batch_done = result_ff.batch_done;
   assign rsp_chan.status     = result_ff.status;

endmodule
